@@ design/qrrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrrs_pkg
// Shared constants and GF(256) helpers for the QR Reed-Solomon encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qrrs_pkg;

   localparam int               BYTE_W             = 8;
   localparam int               PARITY_COUNT_W     = 5;
   localparam int               DEFAULT_MAX_PARITY = 30;
   localparam logic [8:0]       FIELD_POLY         = 9'h11D;
   localparam logic [4:0]       RESET_PARITY       = 5'd7;

   // GF(256) multiply, shift-and-add over the 0x11D field
   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] x;
      acc = '0;
      x   = a;
      for (int i = 0; i < BYTE_W; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? FIELD_POLY[BYTE_W-1:0] : '0);
      end
      return acc;
   endfunction

   // multiply by alpha = 2
   function automatic logic [BYTE_W-1:0] gf_mul_alpha(input logic [BYTE_W-1:0] a);
      return {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? FIELD_POLY[BYTE_W-1:0] : '0);
   endfunction

endpackage

`default_nettype wire

@@ design/qr_reed_solomon_encoder.sv @@
// ----------------------------------------------------------------------------
// qr_reed_solomon_encoder
// Systematic RS parity generator over GF(256), poly 0x11D, parallel LFSR.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake               Payload
// -------  ---  ----------------------  -------------------------------------
// req      in   req_valid / req_ready   req_data_byte[7:0], req_last_byte
// rsp      out  rsp_valid / rsp_ready   rsp_parity_byte[7:0], rsp_last_parity
// csr      in   csr_write_enable        csr_write_data[4:0] (parity_count)
//
// One data word per cycle while req_ready is high: the whole remainder
// register updates at once. On a last word the remainder is copied into a
// parity drain register that emits n words, one per cycle unless rsp_ready
// is low, while the next block keeps streaming in. A last word is held off
// until the previous burst is empty or its final word is being taken.
// After reset and after each parity_count write the generator is rebuilt
// iteratively, one root at a time, with req_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module qr_reed_solomon_encoder
   import qrrs_pkg::*;
#(
   parameter int MAX_PARITY = DEFAULT_MAX_PARITY
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      csr_write_enable,
   input  wire logic [PARITY_COUNT_W-1:0] csr_write_data,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [BYTE_W-1:0]         req_data_byte,
   input  wire logic                      req_last_byte,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [BYTE_W-1:0]              rsp_parity_byte,
   output logic                           rsp_last_parity
);

   // count width holds MAX_PARITY itself; NW covers both count and csr value
   localparam int CW = $clog2(MAX_PARITY + 1);
   localparam int NW = (CW > PARITY_COUNT_W) ? CW : PARITY_COUNT_W;

   typedef enum logic [1:0] {
      ST_INIT,    // seed generator with the constant 1
      ST_BUILD,   // multiply in one root per cycle
      ST_RUN      // encoding
   } state_type;

   state_type                 state_ff, state_in;
   logic [PARITY_COUNT_W-1:0] parity_count_ff, parity_count_in;
   logic [CW-1:0]             iter_ff, iter_in;
   logic [CW-1:0]             rsp_count_ff, rsp_count_in;
   logic [BYTE_W-1:0]         root_ff, root_in;

   logic [BYTE_W-1:0]         gen_ff    [MAX_PARITY];
   logic [BYTE_W-1:0]         gen_in    [MAX_PARITY];
   logic [BYTE_W-1:0]         rem_ff    [MAX_PARITY];
   logic [BYTE_W-1:0]         rem_in    [MAX_PARITY];
   logic [BYTE_W-1:0]         shadow_ff [MAX_PARITY];
   logic [BYTE_W-1:0]         shadow_in [MAX_PARITY];

   logic [BYTE_W-1:0]         gen_init  [MAX_PARITY];
   logic [BYTE_W-1:0]         gen_up    [MAX_PARITY];
   logic [BYTE_W-1:0]         gen_step  [MAX_PARITY];
   logic [BYTE_W-1:0]         rem_up    [MAX_PARITY];
   logic [BYTE_W-1:0]         rem_step  [MAX_PARITY];

   logic [NW-1:0]             pc_ext;
   logic [CW-1:0]             eff_count;
   logic [BYTE_W-1:0]         factor;
   logic                      req_accept;
   logic                      rsp_accept;
   logic                      drain_free;
   logic                      load_parity;

   // effective parity count: zero counts as one, saturate at MAX_PARITY
   assign pc_ext = NW'(parity_count_ff);

   always_comb begin
      if (pc_ext == '0) begin
         eff_count = CW'(1);
      end else if (pc_ext > NW'(MAX_PARITY)) begin
         eff_count = CW'(MAX_PARITY);
      end else begin
         eff_count = CW'(pc_ext);
      end
   end

   // feedback term of the LFSR
   assign factor = req_data_byte ^ rem_ff[0];

   // per-slot arithmetic; slots at or above n stay zero
   for (genvar j = 0; j < MAX_PARITY; j++) begin : g_slot
      if (j < MAX_PARITY - 1) begin : g_up
         assign gen_up[j] = (CW'(j + 1) < eff_count) ? gen_ff[j+1] : '0;
         assign rem_up[j] = (CW'(j + 1) < eff_count) ? rem_ff[j+1] : '0;
      end else begin : g_top
         assign gen_up[j] = '0;
         assign rem_up[j] = '0;
      end
      assign gen_init[j] = (CW'(j) == eff_count - CW'(1)) ? BYTE_W'(1) : '0;
      // generator times (x + root)
      assign gen_step[j] = gf_mul(gen_ff[j], root_ff) ^ gen_up[j];
      // shift toward slot 0, then add generator times feedback
      assign rem_step[j] = rem_up[j] ^ gf_mul(gen_ff[j], factor);
   end

   // drain register can take a new burst if empty or emptying this cycle
   assign drain_free  = (rsp_count_ff == '0) ||
                        ((rsp_count_ff == CW'(1)) && rsp_ready);
   assign req_ready   = (state_ff == ST_RUN) && (!req_last_byte || drain_free);
   assign req_accept  = req_valid && req_ready;
   assign rsp_accept  = rsp_valid && rsp_ready;
   assign load_parity = req_accept && req_last_byte;

   assign rsp_valid       = (rsp_count_ff != '0);
   assign rsp_parity_byte = shadow_ff[0];
   assign rsp_last_parity = (rsp_count_ff == CW'(1));

   always_comb begin
      state_in        = state_ff;
      parity_count_in = parity_count_ff;
      iter_in         = iter_ff;
      rsp_count_in    = rsp_count_ff;
      root_in         = root_ff;
      gen_in          = gen_ff;
      rem_in          = rem_ff;
      shadow_in       = shadow_ff;

      case (state_ff)
         ST_INIT: begin
            gen_in   = gen_init;
            root_in  = BYTE_W'(1);
            iter_in  = '0;
            state_in = ST_BUILD;
         end
         ST_BUILD: begin
            gen_in  = gen_step;
            root_in = gf_mul_alpha(root_ff);
            iter_in = iter_ff + CW'(1);
            if (iter_ff == eff_count - CW'(1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (req_accept) begin
         if (req_last_byte) begin
            rem_in = '{default: '0};
         end else begin
            rem_in = rem_step;
         end
      end

      if (rsp_accept) begin
         for (int j = 0; j < MAX_PARITY - 1; j++) begin
            shadow_in[j] = shadow_ff[j+1];
         end
         shadow_in[MAX_PARITY-1] = '0;
         rsp_count_in = rsp_count_ff - CW'(1);
      end

      if (load_parity) begin
         shadow_in    = rem_step;
         rsp_count_in = eff_count;
      end

      if (csr_write_enable) begin
         parity_count_in = csr_write_data;
         state_in        = ST_INIT;
         rem_in          = '{default: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         parity_count_ff <= RESET_PARITY;
         iter_ff         <= '0;
         rsp_count_ff    <= '0;
         rem_ff          <= '{default: '0};
      end else begin
         state_ff        <= state_in;
         parity_count_ff <= parity_count_in;
         iter_ff         <= iter_in;
         rsp_count_ff    <= rsp_count_in;
         rem_ff          <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff   <= root_in;
      gen_ff    <= gen_in;
      shadow_ff <= shadow_in;
   end

endmodule

`default_nettype wire

@@ design/qrrs_checker.sv @@
// ----------------------------------------------------------------------------
// qrrs_checker
// Port-level checks for the QR Reed-Solomon encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qrrs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       csr_write_enable,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_last_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_parity_byte,
   input wire logic       rsp_last_parity
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_parity_byte) &&
                                  $stable(rsp_last_parity))
      else $error("rsp word changed while stalled");

   // generator rebuild after reset: nothing in, nothing out
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   // csr write restarts the generator build
   a_csr_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !req_ready)
      else $error("input taken during generator rebuild");

   // a last word only enters when the previous burst is done
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |->
         !rsp_valid || (rsp_ready && rsp_last_parity))
      else $error("parity burst overrun");

   // a last word starts a parity burst
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte && !csr_write_enable |=> rsp_valid)
      else $error("no parity after last word");

endmodule

bind qr_reed_solomon_encoder qrrs_checker u_qrrs_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the QR Reed-Solomon parity encoder. Data words are
// streamed in as blocks under several parity counts. Each parity word is
// checked against a GF(256) model that uses log/antilog tables.
// ----------------------------------------------------------------------------
module tb
   import qrrs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 10;
   localparam int MODEL_MAX     = DEFAULT_MAX_PARITY;
   localparam int LIMIT_CYCLES  = 200000;
   // covers the generator rebuild and any word still in flight
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PCT      = 17;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 40;
   localparam int PHASE_COUNT   = 8;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } data_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] parity;
      logic              last;
   } parity_word_type;

   // ---------------------------------------------------------------- DUT I/O
   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [PARITY_COUNT_W-1:0] csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic [BYTE_W-1:0]         req_data_byte    = '0;
   logic                      req_last_byte    = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic [BYTE_W-1:0]         rsp_parity_byte;
   logic                      rsp_last_parity;

   qr_reed_solomon_encoder #(
      .MAX_PARITY (MODEL_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_parity_byte  (rsp_parity_byte),
      .rsp_last_parity  (rsp_last_parity)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // ------------------------------------------------------------ bench state
   data_word_type   pending_words[$];     // words waiting for the driver
   parity_word_type expected_parity[$];   // parity words the encoder still owes
   data_word_type   send_word;
   parity_word_type head_word;

   logic steady      = 1'b0;   // no random idling on either side
   logic hold_wanted = 1'b0;   // ask the receiver for its one long hold-off
   logic hold_done   = 1'b0;
   int   hold_left   = 0;
   logic word_taken  = 1'b0;

   int fail_count     = 0;
   int cycle_count    = 0;
   int words_sent     = 0;
   int parity_checked = 0;
   int settings_used  = 0;

   // -------------------------------------------------------- parity predictor
   // GF(256) by log/antilog tables over the 0x11D field, alpha = 2.
   logic [BYTE_W-1:0] alpha_pow[0:254];
   int                alpha_log[0:255];

   int                        model_n;
   logic [BYTE_W-1:0]         model_rem[0:MODEL_MAX-1];
   logic [BYTE_W-1:0]         model_gen[0:MODEL_MAX-1];

   function automatic logic [BYTE_W-1:0] gf_product(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
      if (a == '0 || b == '0) begin
         return '0;
      end
      return alpha_pow[(alpha_log[a] + alpha_log[b]) % 255];
   endfunction

   function automatic void build_field_tables();
      int v;
      v = 1;
      for (int i = 0; i < 255; i++) begin
         alpha_pow[i] = v[BYTE_W-1:0];
         alpha_log[v] = i;
         v = v << 1;
         if (v & 'h100) begin
            v = v ^ int'(FIELD_POLY);
         end
      end
      alpha_log[0] = 0;   // never used, log of zero is undefined
   endfunction

   // New parity count: clamp, clear the remainder, expand prod (x + alpha^i).
   function automatic void load_parity_count(input logic [PARITY_COUNT_W-1:0] value);
      logic [BYTE_W-1:0] poly[0:MODEL_MAX];
      logic [BYTE_W-1:0] root;
      model_n   = (value == 0) ? 1 : (int'(value) > MODEL_MAX) ? MODEL_MAX : int'(value);
      for (int k = 0; k <= MODEL_MAX; k++) begin
         poly[k] = '0;
      end
      poly[0] = 8'd1;
      root    = 8'd1;
      for (int i = 0; i < model_n; i++) begin
         for (int k = i + 1; k >= 1; k--) begin
            poly[k] = poly[k-1] ^ gf_product(poly[k], root);
         end
         poly[0] = gf_product(poly[0], root);
         root    = gf_product(root, 8'd2);
      end
      // descending order, leading 1 dropped
      for (int j = 0; j < MODEL_MAX; j++) begin
         model_rem[j] = '0;
         model_gen[j] = (j < model_n) ? poly[model_n-1-j] : '0;
      end
   endfunction

   function automatic void encode_word(input logic [BYTE_W-1:0] data, input logic last);
      logic [BYTE_W-1:0] factor;
      parity_word_type   pw;
      factor = data ^ model_rem[0];
      for (int j = 0; j + 1 < model_n; j++) begin
         model_rem[j] = model_rem[j+1];
      end
      model_rem[model_n-1] = '0;
      for (int j = 0; j < model_n; j++) begin
         model_rem[j] = model_rem[j] ^ gf_product(model_gen[j], factor);
      end
      if (last) begin
         for (int j = 0; j < model_n; j++) begin
            pw.parity = model_rem[j];
            pw.last   = (j == model_n - 1);
            expected_parity.push_back(pw);
            model_rem[j] = '0;
         end
      end
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------ driver
   // Sample the request handshake at the rising edge, act on it at the falling.
   always @(posedge clock) begin
      word_taken <= req_valid && req_ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         // current word gone (or none): offer the next one unless idling
         if (pending_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            send_word      = pending_words.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= send_word.data;
            req_last_byte <= send_word.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // One long hold-off on request, counted here; otherwise random gaps unless steady.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ----------------------------------------------------------------- monitor
   // Check the output before predicting this edge's input: a parity word on
   // the bus now can only come from words accepted earlier.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            parity_checked++;
            if (expected_parity.size() == 0) begin
               report_mismatch($sformatf("unexpected parity word %02h last %0b",
                                         rsp_parity_byte, rsp_last_parity));
            end else begin
               head_word = expected_parity.pop_front();
               if (rsp_parity_byte !== head_word.parity) begin
                  report_mismatch($sformatf("parity_byte %02h, expected %02h",
                                            rsp_parity_byte, head_word.parity));
               end
               if (rsp_last_parity !== head_word.last) begin
                  report_mismatch($sformatf("last_parity %0b, expected %0b",
                                            rsp_last_parity, head_word.last));
               end
            end
         end
         if (req_valid && req_ready) begin
            words_sent++;
            encode_word(req_data_byte, req_last_byte);
         end
      end
   end

   // ------------------------------------------------------------------ watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d parity words outstanding",
                  cycle_count, expected_parity.size());
         $display("FAIL");
         $finish;
      end
   end

   // --------------------------------------------------------------- stimulus
   task automatic queue_word(input logic [BYTE_W-1:0] data, input logic last);
      data_word_type w;
      w.data = data;
      w.last = last;
      pending_words.push_back(w);
   endtask

   // Block fully drained: nothing queued, nothing offered, nothing owed.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_words.size() != 0 || req_valid || expected_parity.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write at one rising edge; the model follows once it has landed.
   task automatic write_parity_count(input logic [PARITY_COUNT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      load_parity_count(value);
      settings_used++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hFF;
      end
      return BYTE_W'($urandom_range(255));
   endfunction

   // Mostly short blocks, a few long ones; sometimes a dangling tail that the
   // next parity_count write throws away.
   task automatic queue_random_phase(input int word_budget);
      int left;
      int len;
      int r;
      left = word_budget;
      while (left > 0) begin
         r   = $urandom_range(99);
         len = (r < 70) ? $urandom_range(1, 6) :
               (r < 92) ? $urandom_range(7, 20) : $urandom_range(21, 45);
         for (int k = 0; k < len; k++) begin
            queue_word(pick_byte(), k == len - 1);
         end
         left -= len;
      end
      if ($urandom_range(1) == 1) begin
         len = $urandom_range(1, 4);
         for (int k = 0; k < len; k++) begin
            queue_word(pick_byte(), 1'b0);
         end
      end
   endtask

   initial begin
      logic [PARITY_COUNT_W-1:0] setting;

      build_field_tables();
      load_parity_count(RESET_PARITY);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed: reset count of seven
      queue_word(8'h00, 1'b1);              // all-zero block, all-zero parity
      queue_word(8'hFF, 1'b1);
      queue_word(8'h80, 1'b0);
      queue_word(8'h01, 1'b0);
      queue_word(8'h7F, 1'b0);
      queue_word(8'h55, 1'b0);
      queue_word(8'hAA, 1'b1);
      wait_idle();

      // zero count acts as one parity word
      write_parity_count(5'd0);
      queue_word(8'h12, 1'b1);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b1);
      wait_idle();

      // 31 saturates to the maximum
      write_parity_count(5'd31);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h01, 1'b1);
      wait_idle();

      // largest legal count, then a block left open and discarded by the write
      write_parity_count(5'd30);
      queue_word(8'hC3, 1'b1);
      queue_word(8'h5A, 1'b0);
      queue_word(8'hA5, 1'b0);
      wait_idle();

      // smallest count, back-to-back single-word blocks
      write_parity_count(5'd1);
      queue_word(8'hFF, 1'b1);
      queue_word(8'h00, 1'b1);
      wait_idle();

      // --- random phases
      // phase 0: full-size generator plus the long receiver hold-off, so the
      //          drain register backs up and the input is stalled
      // phase 1: smallest count with no idling anywhere
      // rest   : any 5-bit value, zero and 31 included
      for (int p = 0; p < PHASE_COUNT; p++) begin
         setting = (p == 0) ? 5'd30 : (p == 1) ? 5'd1 : 5'($urandom_range(31));
         write_parity_count(setting);
         steady      = (p == 1);
         hold_wanted = (p == 0);
         queue_random_phase(PHASE_WORDS);
         wait_idle();
      end
      steady = 1'b0;

      $display("covered %0d data words, %0d parity words checked, %0d count writes",
               words_sent, parity_checked, settings_used);
      $display("counts 0, 1, 7, 30, 31 and random; one %0d-cycle receiver hold-off",
               HOLD_CYCLES);

      if (expected_parity.size() != 0) begin
         report_mismatch($sformatf("%0d parity words never arrived",
                                   expected_parity.size()));
      end
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
